/* rtl/core/cpwt_pkg.sv */
// Package for the child pose world transform core.
// Holds the input and result transaction structs, function codes and the table size;
// no dependencies.
package cpwt_pkg;

    localparam logic FUNC_STORE     = 1'b0;
    localparam logic FUNC_TRANSFORM = 1'b1;

    // Parent table depth; the 8-bit slot field addresses it directly.
    localparam int PARENT_SLOTS = 256;
    localparam int SLOT_W       = $clog2(PARENT_SLOTS);

    typedef struct packed {
        logic               func;
        logic [7:0]         slot;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] ori_x;
        logic signed [15:0] ori_y;
        logic               last_part;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [15:0] orient_x;
        logic signed [15:0] orient_y;
        logic               degenerate;
        logic               last_out;
    } t_out_item;

endpackage

/* rtl/core/child_pose_world_transform_core.sv */
// Top level of the child pose world transform core.
// Depends on cpwt_pkg for the transaction structs, function codes and table size.
//
// The core keeps a table of PARENT_SLOTS parent poses in two synchronous memories (position
// and orientation, registered read). A store transaction writes one parent entry in the
// cycle it is accepted and produces no result; the next transaction can follow in the next
// cycle. A transform transaction reads its parent, rotates the local offset by the parent
// orientation, adds the parent position with saturation, composes the orientations and
// normalizes the product to unit length (a zero-length product gives unit x, degenerate set).
// Its result passes through the memory read, products and sums, the bit-serial square root (a
// setup step, 32 bit-pair steps on the 64-bit squared length and a hand-off step), two
// restoring divisions for the normalized components (a setup step, 48 quotient bits and a
// finishing step each) and the load of the output register. The input is closed from
// acceptance until the output register is loaded, so a transform is through before the next
// transaction is taken. The input is ready again while a finished result waits in the output
// register; a second transform then holds its result in the last stage, and keeps the input
// closed, until the first one leaves. A read of a slot that was never stored is undefined.
// The slot index wraps modulo PARENT_SLOTS.
module child_pose_world_transform_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  cpwt_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output cpwt_pkg::t_out_item o_data
);
    import cpwt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_MUL1, S_MUL2, S_SUM, S_SQRT, S_DIVX, S_DIVY, S_OUT
    } t_state;

    logic [63:0] r_pos_mem [PARENT_SLOTS];
    logic [31:0] r_ori_mem [PARENT_SLOTS];
    logic [63:0] r_pos_rd;
    logic [31:0] r_ori_rd;

    t_state r_state;
    t_in_item r_item;
    logic [SLOT_W-1:0] w_idx;

    // Products and sums.
    logic signed [47:0] r_p_xx, r_p_yy, r_p_xy, r_p_yx;
    logic signed [31:0] r_c_xx, r_c_yy, r_c_xy, r_c_yx;
    logic signed [32:0] r_cx, r_cy;
    logic signed [31:0] r_wx, r_wy;
    logic [63:0] r_len2;

    // Square root (bit pair per cycle).
    logic [63:0] r_rem;
    logic [63:0] r_root;
    logic [63:0] r_bit;
    logic [5:0]  r_cnt;

    // Division.
    logic [47:0] r_num;
    logic [47:0] r_q;
    logic [48:0] r_drem;
    logic [32:0] r_den;
    logic signed [15:0] r_ox;
    logic signed [15:0] r_oy;
    logic r_degen;
    logic r_valid;
    t_out_item r_out;

    assign w_idx = i_data.slot[SLOT_W-1:0];
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;
    assign o_data = r_out;

    // Memories: write on store, read every accept.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            if (i_data.func == FUNC_STORE) begin
                r_pos_mem[w_idx] <= {i_data.pos_x, i_data.pos_y};
                r_ori_mem[w_idx] <= {i_data.ori_x, i_data.ori_y};
            end
            r_pos_rd <= r_pos_mem[w_idx];
            r_ori_rd <= r_ori_mem[w_idx];
        end
    end

    logic signed [15:0] w_qx, w_qy;
    logic signed [34:0] w_rx_s, w_ry_s;
    logic signed [48:0] w_rsx, w_rsy;
    logic signed [34:0] w_sx, w_sy;
    logic signed [65:0] w_cx2, w_cy2;
    logic [63:0] w_try;
    logic [48:0] w_trial;
    assign w_qx = r_ori_rd[31:16];
    assign w_qy = r_ori_rd[15:0];
    assign w_rsx = 49'(r_p_xx) - 49'(r_p_yy) + 49'sd8192;
    assign w_rsy = 49'(r_p_xy) + 49'(r_p_yx) + 49'sd8192;
    assign w_rx_s = 35'(w_rsx >>> 14);
    assign w_ry_s = 35'(w_rsy >>> 14);
    // The rotated offset alone can reach 2^33, so the sum needs 35 bits before clamping.
    assign w_sx = 35'($signed(r_pos_rd[63:32])) + w_rx_s;
    assign w_sy = 35'($signed(r_pos_rd[31:0])) + w_ry_s;
    assign w_cx2 = r_cx * r_cx;
    assign w_cy2 = r_cy * r_cy;
    assign w_try = r_root + r_bit;
    assign w_trial = {r_drem[47:0], r_num[47]};
    // Quotient saturation to 16 bits (magnitude up to 32768 fits only for negative).
    function automatic logic signed [15:0] f_sat(input logic [47:0] q, input logic neg);
        if (neg) f_sat = (q > 48'd32768) ? 16'sh8000 : 16'(-$signed({1'b0, q[15:0]}));
        else     f_sat = (q > 48'd32767) ? 16'sh7fff : q[15:0];
    endfunction

    function automatic logic signed [31:0] f_clamp(input logic signed [34:0] v);
        if (v > 35'sd2147483647)       f_clamp = 32'sh7fffffff;
        else if (v < -35'sd2147483648) f_clamp = 32'sh80000000;
        else                           f_clamp = v[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && i_ready) r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_item <= i_data;
                        if (i_data.func == FUNC_TRANSFORM) r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_p_xx <= r_item.pos_x * w_qx;
                    r_p_yy <= r_item.pos_y * w_qy;
                    r_c_xx <= r_item.ori_x * w_qx;
                    r_c_yy <= r_item.ori_y * w_qy;
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_p_xy <= r_item.pos_x * w_qy;
                    r_p_yx <= r_item.pos_y * w_qx;
                    r_c_xy <= r_item.ori_x * w_qy;
                    r_c_yx <= r_item.ori_y * w_qx;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_wx <= f_clamp(w_sx);
                    r_wy <= f_clamp(w_sy);
                    r_cx <= 33'(r_c_xx) - 33'(r_c_yy);
                    r_cy <= 33'(r_c_xy) + 33'(r_c_yx);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_len2 <= 64'(w_cx2) + 64'(w_cy2);
                    r_cnt <= '0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_cnt == 6'd0) begin
                        r_rem <= r_len2;
                        r_root <= '0;
                        r_bit <= 64'h4000_0000_0000_0000;
                        r_cnt <= 6'd1;
                    end else if (r_cnt == 6'd33) begin
                        r_degen <= (r_len2 == 64'd0);
                        r_den <= r_root[32:0];
                        r_num <= {1'b0, (r_cx[32] ? 33'(-r_cx) : 33'(r_cx)), 14'd0} << 1;
                        r_drem <= '0;
                        r_cnt <= '0;
                        r_state <= S_DIVX;
                    end else begin
                        if (r_rem >= w_try) begin
                            r_rem <= r_rem - w_try;
                            r_root <= (r_root >> 1) + r_bit;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_bit <= r_bit >> 2;
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_DIVX, S_DIVY: begin
                    // Computes floor((2*mag*16384 + m) / (2*m)) bit by bit: numerator
                    // (2*mag<<14) + m over 2m, done as restoring division on 48 bits.
                    if (r_cnt == 6'd0) begin
                        r_num <= r_num + 48'(r_den);
                        r_q <= '0;
                        r_cnt <= 6'd1;
                    end else if (r_cnt <= 6'd48) begin
                        if (w_trial >= {15'd0, r_den, 1'b0}) begin
                            r_drem <= w_trial - {15'd0, r_den, 1'b0};
                            r_q <= {r_q[46:0], 1'b1};
                        end else begin
                            r_drem <= w_trial;
                            r_q <= {r_q[46:0], 1'b0};
                        end
                        r_num <= r_num << 1;
                        r_cnt <= r_cnt + 6'd1;
                    end else if (r_state == S_DIVX) begin
                        r_ox <= f_sat(r_q, r_cx[32]);
                        r_num <= {1'b0, (r_cy[32] ? 33'(-r_cy) : 33'(r_cy)), 14'd0} << 1;
                        r_drem <= '0;
                        r_cnt <= '0;
                        r_state <= S_DIVY;
                    end else begin
                        r_oy <= f_sat(r_q, r_cy[32]);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // The output register is loaded only once the previous result has left.
                    if (!r_valid) begin
                        r_out.world_x <= r_wx;
                        r_out.world_y <= r_wy;
                        r_out.orient_x <= r_degen ? 16'sd16384 : r_ox;
                        r_out.orient_y <= r_degen ? 16'sd0 : r_oy;
                        r_out.degenerate <= r_degen;
                        r_out.last_out <= r_item.last_part;
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("result changed or dropped while waiting");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT && r_cnt == 6'd33) |-> r_root[63:33] == '0)
        else $error("square root wider than 33 bits");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.degenerate |-> o_data.orient_x == 16'sd16384)
        else $error("degenerate result without unit x");

endmodule
